// ----- hw/rtl/rgvc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgvc_pkg: shared types and constants of the region grow voxel criterion
// field widths, word layouts, reason and function codes, register indexes
// ----------------------------------------------------------------------------
package rgvc_pkg;

	localparam int COORD_W     = 10;
	localparam int VALUE_W     = 16;
	localparam int SPACING_W   = 16;
	localparam int RADIUS_W    = 56;
	localparam int PROD_W      = COORD_W + SPACING_W;
	localparam int SQ_W        = 2 * PROD_W;
	localparam int SEED_TOT_W  = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = RADIUS_W;

	typedef enum logic [1:0] {
		FUNC_EVAL   = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		RSN_ACCEPTED     = 3'd0,
		RSN_OUT_OF_RANGE = 3'd1,
		RSN_NO_OVERWRITE = 3'd2,
		RSN_OUTSIDE_ROI  = 3'd3,
		RSN_OUTSIDE_RAD  = 3'd4,
		RSN_SEED_DONE    = 3'd5,
		RSN_TABLE_FULL   = 3'd6
	} reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VALUE_MIN     = 3'd0,
		CFG_VALUE_MAX     = 3'd1,
		CFG_OVERWRITE     = 3'd2,
		CFG_RADIUS_ON     = 3'd3,
		CFG_RADIUS_SQ     = 3'd4,
		CFG_SPACING_X     = 3'd5,
		CFG_SPACING_Y     = 3'd6,
		CFG_SPACING_Z     = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} coord_t;

	typedef struct packed {
		logic [1:0]                func;
		logic [COORD_W-1:0]        pos_x;
		logic [COORD_W-1:0]        pos_y;
		logic [COORD_W-1:0]        pos_z;
		logic signed [VALUE_W-1:0] voxel_value;
		logic                      roi_ok;
	} item_t;

	typedef struct packed {
		logic                  accept;
		reason_t               reason;
		logic [SEED_TOT_W-1:0] seed_total;
	} result_t;

	// status of the distance pipeline toward the sequencer
	typedef struct packed {
		logic busy;
		logic hit_valid;
		logic hit;
	} dist_stat_t;

	localparam logic signed [VALUE_W-1:0] VALUE_MIN_RST = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MAX_RST = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [RADIUS_W-1:0]       RADIUS_RST    = {RADIUS_W{1'b1}};
	localparam logic [SPACING_W-1:0]      SPACING_RST   = 16'd256;

endpackage
`default_nettype wire

// ----- hw/rtl/region_grow_voxel_criterion.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// region_grow_voxel_criterion: region growing voxel admission check
// seed table in a memory, sequencer and a three-lane distance pipeline
// ----------------------------------------------------------------------------
// The block takes one word at a time: evaluate a voxel, append a seed or clear
// the seed table, and returns one result word for each. Append and clear words,
// and evaluate words that fail the value, overwrite or roi checks, run with
// the radius check off or meet an empty table, go from the check state
// straight to the emit state, which loads the output register. An evaluate
// word that reaches the radius check with stored seeds walks them through
// the seed memory read port, one seed per cycle, into a distance pipeline
// of three stages and goes to the emit state once that pipeline has drained.
// The next word is taken as soon as a result sits in the output register,
// even if it is not yet taken. Configuration is written through cfg_we /
// cfg_index / cfg_data and must only change while the block is idle. The
// seed table needs no clearing after reset; only entries below the seed
// count are ever read.
module region_grow_voxel_criterion #(
	parameter int MAX_SEEDS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_ready,
	input  wire rgvc_pkg::item_t                    item,
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output rgvc_pkg::result_t                       result,
	input  wire logic                               cfg_we,
	input  wire logic [rgvc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rgvc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
	localparam int CNT_W = $clog2(MAX_SEEDS + 1);
	localparam logic [CNT_W-1:0] SEED_LIMIT = CNT_W'(MAX_SEEDS);

	// configuration registers
	logic signed [rgvc_pkg::VALUE_W-1:0] value_min_q, value_max_q;
	logic                                overwrite_q, radius_on_q;
	logic [rgvc_pkg::RADIUS_W-1:0]       radius_sq_q;
	logic [rgvc_pkg::SPACING_W-1:0]      spacing_x_q, spacing_y_q, spacing_z_q;

	// sequencer state
	rgvc_pkg::state_t    state_q, state_d;
	rgvc_pkg::item_t     item_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    issue_q, issue_d;
	logic                hit_q, hit_d;
	rgvc_pkg::result_t   res_q, res_d;
	rgvc_pkg::result_t   result_q;
	logic                result_valid_q;
	logic                load_out;

	// memory and distance unit hookup
	logic                mem_we, mem_rd_en, mem_rd_valid;
	rgvc_pkg::coord_t    mem_wr_data, mem_rd_data, voxel_pos;
	rgvc_pkg::dist_stat_t dist_stat;

	logic                out_of_range;

	// config write, one register per index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_min_q <= rgvc_pkg::VALUE_MIN_RST;
			value_max_q <= rgvc_pkg::VALUE_MAX_RST;
			overwrite_q <= 1'b0;
			radius_on_q <= 1'b0;
			radius_sq_q <= rgvc_pkg::RADIUS_RST;
			spacing_x_q <= rgvc_pkg::SPACING_RST;
			spacing_y_q <= rgvc_pkg::SPACING_RST;
			spacing_z_q <= rgvc_pkg::SPACING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rgvc_pkg::CFG_VALUE_MIN: value_min_q <= cfg_data[rgvc_pkg::VALUE_W-1:0];
				rgvc_pkg::CFG_VALUE_MAX: value_max_q <= cfg_data[rgvc_pkg::VALUE_W-1:0];
				rgvc_pkg::CFG_OVERWRITE: overwrite_q <= cfg_data[0];
				rgvc_pkg::CFG_RADIUS_ON: radius_on_q <= cfg_data[0];
				rgvc_pkg::CFG_RADIUS_SQ: radius_sq_q <= cfg_data[rgvc_pkg::RADIUS_W-1:0];
				rgvc_pkg::CFG_SPACING_X: spacing_x_q <= cfg_data[rgvc_pkg::SPACING_W-1:0];
				rgvc_pkg::CFG_SPACING_Y: spacing_y_q <= cfg_data[rgvc_pkg::SPACING_W-1:0];
				rgvc_pkg::CFG_SPACING_Z: spacing_z_q <= cfg_data[rgvc_pkg::SPACING_W-1:0];
				default: ;
			endcase
		end
	end

	// seed coordinates live here
	assign voxel_pos.x = item_q.pos_x;
	assign voxel_pos.y = item_q.pos_y;
	assign voxel_pos.z = item_q.pos_z;
	assign mem_wr_data = voxel_pos;

	rgvc_seed_mem #(
		.DEPTH  (MAX_SEEDS),
		.ADDR_W (IDX_W)
	) u_seed_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mem_we),
		.wr_addr  (count_q[IDX_W-1:0]),
		.wr_data  (mem_wr_data),
		.rd_en    (mem_rd_en),
		.rd_addr  (issue_q[IDX_W-1:0]),
		.rd_data  (mem_rd_data),
		.rd_valid (mem_rd_valid)
	);

	// one seed per cycle through the distance lanes
	rgvc_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_valid (mem_rd_valid),
		.seed       (mem_rd_data),
		.voxel      (voxel_pos),
		.spacing_x  (spacing_x_q),
		.spacing_y  (spacing_y_q),
		.spacing_z  (spacing_z_q),
		.radius_sq  (radius_sq_q),
		.stat       (dist_stat)
	);

	assign out_of_range = (item_q.voxel_value < value_min_q) ||
	                      (item_q.voxel_value > value_max_q);

	// sequencer: next state and controls
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		mem_we     = 1'b0;
		mem_rd_en  = 1'b0;
		count_d    = count_q;
		issue_d    = issue_q;
		hit_d      = hit_q | (dist_stat.hit_valid & dist_stat.hit);
		res_d      = res_q;
		load_out   = 1'b0;
		case (state_q)
			rgvc_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = rgvc_pkg::ST_CHECK;
				end
			end
			rgvc_pkg::ST_CHECK: begin
				// checks in priority order, first failure names the reason
				res_d.accept = 1'b0;
				res_d.reason = rgvc_pkg::RSN_SEED_DONE;
				state_d      = rgvc_pkg::ST_EMIT;
				issue_d      = '0;
				hit_d        = 1'b0;
				case (item_q.func)
					rgvc_pkg::FUNC_EVAL: begin
						if (out_of_range) begin
							res_d.reason = rgvc_pkg::RSN_OUT_OF_RANGE;
						end else if (!overwrite_q && (item_q.voxel_value != '0)) begin
							res_d.reason = rgvc_pkg::RSN_NO_OVERWRITE;
						end else if (!item_q.roi_ok) begin
							res_d.reason = rgvc_pkg::RSN_OUTSIDE_ROI;
						end else if (radius_on_q) begin
							if (count_q == '0) begin
								res_d.reason = rgvc_pkg::RSN_OUTSIDE_RAD;
							end else begin
								state_d = rgvc_pkg::ST_SCAN;
							end
						end else begin
							res_d.accept = 1'b1;
							res_d.reason = rgvc_pkg::RSN_ACCEPTED;
						end
					end
					rgvc_pkg::FUNC_APPEND: begin
						if (count_q >= SEED_LIMIT) begin
							res_d.reason = rgvc_pkg::RSN_TABLE_FULL;
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end
					rgvc_pkg::FUNC_CLEAR: begin
						count_d = '0;
					end
					default: ;
				endcase
				res_d.seed_total = rgvc_pkg::SEED_TOT_W'(count_d);
			end
			rgvc_pkg::ST_SCAN: begin
				// issue reads until every stored seed is in flight, then drain
				if (issue_q < count_q) begin
					mem_rd_en = 1'b1;
					issue_d   = issue_q + CNT_W'(1);
				end else if (!mem_rd_valid && !dist_stat.busy) begin
					res_d.accept = hit_q;
					res_d.reason = hit_q ? rgvc_pkg::RSN_ACCEPTED : rgvc_pkg::RSN_OUTSIDE_RAD;
					state_d      = rgvc_pkg::ST_EMIT;
				end
			end
			rgvc_pkg::ST_EMIT: begin
				// wait for a free output register
				if (!result_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = rgvc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rgvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rgvc_pkg::ST_IDLE;
			count_q        <= '0;
			issue_q        <= '0;
			hit_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			issue_q <= issue_d;
			hit_q   <= hit_d;
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		res_q <= res_d;
		if (load_out) begin
			result_q <= res_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rgvc_seed_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgvc_seed_mem: seed coordinate store
// one write port, one read port with registered data and valid
// ----------------------------------------------------------------------------
module rgvc_seed_mem #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire rgvc_pkg::coord_t    wr_data,
	input  wire logic                rd_en,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	output rgvc_pkg::coord_t         rd_data,
	output logic                     rd_valid
);

	rgvc_pkg::coord_t mem [DEPTH];
	rgvc_pkg::coord_t rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rgvc_dist.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgvc_dist: seed distance pipeline
// three axis lanes, spacing multiply, square, sum and radius compare
// ----------------------------------------------------------------------------
module rgvc_dist (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               seed_valid,
	input  wire rgvc_pkg::coord_t                   seed,
	input  wire rgvc_pkg::coord_t                   voxel,
	input  wire logic [rgvc_pkg::SPACING_W-1:0]     spacing_x,
	input  wire logic [rgvc_pkg::SPACING_W-1:0]     spacing_y,
	input  wire logic [rgvc_pkg::SPACING_W-1:0]     spacing_z,
	input  wire logic [rgvc_pkg::RADIUS_W-1:0]      radius_sq,
	output rgvc_pkg::dist_stat_t                    stat
);

	logic [rgvc_pkg::COORD_W-1:0]   seed_ax [3];
	logic [rgvc_pkg::COORD_W-1:0]   vox_ax  [3];
	logic [rgvc_pkg::SPACING_W-1:0] sp_ax   [3];
	logic [rgvc_pkg::COORD_W-1:0]   diff_ax [3];
	logic [rgvc_pkg::PROD_W-1:0]    p_s1    [3];
	logic [rgvc_pkg::SQ_W-1:0]      sq_s2   [3];
	logic [rgvc_pkg::RADIUS_W-1:0]  sum;
	logic                           valid_s1, valid_s2, valid_s3;
	logic                           hit_s3;

	assign seed_ax[0] = seed.x;
	assign seed_ax[1] = seed.y;
	assign seed_ax[2] = seed.z;
	assign vox_ax[0]  = voxel.x;
	assign vox_ax[1]  = voxel.y;
	assign vox_ax[2]  = voxel.z;
	assign sp_ax[0]   = spacing_x;
	assign sp_ax[1]   = spacing_y;
	assign sp_ax[2]   = spacing_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_ax[i] = (vox_ax[i] >= seed_ax[i]) ? (vox_ax[i] - seed_ax[i])
			                                       : (seed_ax[i] - vox_ax[i]);
		end
	end

	// three squares of 52 bits never reach 2^56, the width of the sum, so no saturation
	assign sum = rgvc_pkg::RADIUS_W'(sq_s2[0]) + rgvc_pkg::RADIUS_W'(sq_s2[1])
	           + rgvc_pkg::RADIUS_W'(sq_s2[2]);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s1[i]  <= rgvc_pkg::PROD_W'(diff_ax[i]) * rgvc_pkg::PROD_W'(sp_ax[i]);
			sq_s2[i] <= rgvc_pkg::SQ_W'(p_s1[i]) * rgvc_pkg::SQ_W'(p_s1[i]);
		end
		hit_s3 <= (sum < radius_sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= seed_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign stat.busy      = valid_s1 | valid_s2 | valid_s3;
	assign stat.hit_valid = valid_s3;
	assign stat.hit       = hit_s3;

endmodule
`default_nettype wire

// ----- hw/rtl/rgvc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgvc_checker: port-level assertions for the voxel criterion
// bound to the top level
// ----------------------------------------------------------------------------
module rgvc_checker #(
	parameter int MAX_SEEDS = 16
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               item_valid,
	input wire logic                               item_ready,
	input wire rgvc_pkg::item_t                    item,
	input wire logic                               result_valid,
	input wire logic                               result_ready,
	input wire rgvc_pkg::result_t                  result
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// a waiting input word holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input word changed while waiting");

	// accept flag and reason code agree
	a_accept_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.accept == (result.reason == rgvc_pkg::RSN_ACCEPTED)))
		else $error("accept flag disagrees with reason");

	// one word in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second word taken while one is in work");

	// a full table reports its full count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.reason == rgvc_pkg::RSN_TABLE_FULL)
		|-> result.seed_total == rgvc_pkg::SEED_TOT_W'(MAX_SEEDS))
		else $error("table full with wrong seed count");

endmodule

bind region_grow_voxel_criterion rgvc_checker #(
	.MAX_SEEDS (MAX_SEEDS)
) u_rgvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

// ----- sim/rgvc_verdict_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgvc_verdict_checker: result checker for the region grow voxel criterion
// mirrors the registers and the seed table, predicts one verdict per word
// ----------------------------------------------------------------------------
module rgvc_verdict_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	input  wire logic                                  item_ready,
	input  rgvc_pkg::item_t                            item,
	input  wire logic                                  result_valid,
	input  wire logic                                  result_ready,
	input  rgvc_pkg::result_t                          result,
	input  wire logic                                  cfg_we,
	input  wire logic [rgvc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [rgvc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                         errors,
	output int                                         outstanding
);
	import rgvc_pkg::*;

	localparam int SEED_SLOTS = 16;

	// register mirror
	logic signed [VALUE_W-1:0] lim_lo;
	logic signed [VALUE_W-1:0] lim_hi;
	logic                      may_overwrite;
	logic                      radius_on;
	logic [RADIUS_W-1:0]       rad_sq;
	logic [SPACING_W-1:0]      step_x;
	logic [SPACING_W-1:0]      step_y;
	logic [SPACING_W-1:0]      step_z;

	// seed table mirror
	coord_t seeds [SEED_SLOTS];
	int     seeds_held;

	result_t verdicts_due [$];
	result_t want;
	int      words_out;

	task automatic report_mismatch(input string msg);
		$display("ERROR: result word %0d: %s", words_out, msg);
		errors++;
	endtask

	function automatic logic [63:0] axis_sq(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b, input logic [SPACING_W-1:0] sp);
		logic [COORD_W-1:0] d;
		logic [63:0]        p;
		d = (a >= b) ? a - b : b - a;
		p = 64'(d) * 64'(sp);
		return p * p;
	endfunction

	// three squares of at most 52 bits each cannot overflow 64 bits
	function automatic logic near_seed(input coord_t at);
		logic [63:0] d2;
		for (int i = 0; i < seeds_held; i++) begin
			d2 = axis_sq(at.x, seeds[i].x, step_x)
				+ axis_sq(at.y, seeds[i].y, step_y)
				+ axis_sq(at.z, seeds[i].z, step_z);
			if (d2 < {8'b0, rad_sq})
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// verdict for one word; seed operations update the table mirror
	function automatic result_t judge_word(input item_t w);
		result_t                   r;
		logic signed [VALUE_W-1:0] v;
		coord_t                    at;
		v = w.voxel_value;
		at.x = w.pos_x;
		at.y = w.pos_y;
		at.z = w.pos_z;
		r.accept = 1'b0;
		r.reason = RSN_SEED_DONE;
		case (w.func)
			FUNC_EVAL: begin
				if (v < lim_lo || v > lim_hi)
					r.reason = RSN_OUT_OF_RANGE;
				else if (!may_overwrite && v != 0)
					r.reason = RSN_NO_OVERWRITE;
				else if (!w.roi_ok)
					r.reason = RSN_OUTSIDE_ROI;
				else if (radius_on && !near_seed(at))
					r.reason = RSN_OUTSIDE_RAD;
				else begin
					r.reason = RSN_ACCEPTED;
					r.accept = 1'b1;
				end
			end
			FUNC_APPEND: begin
				if (seeds_held >= SEED_SLOTS)
					r.reason = RSN_TABLE_FULL;
				else begin
					seeds[seeds_held] = at;
					seeds_held++;
				end
			end
			FUNC_CLEAR: seeds_held = 0;
			default: ;
		endcase
		r.seed_total = SEED_TOT_W'(seeds_held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_lo        = VALUE_MIN_RST;
			lim_hi        = VALUE_MAX_RST;
			may_overwrite = 1'b0;
			radius_on     = 1'b0;
			rad_sq        = RADIUS_RST;
			step_x        = SPACING_RST;
			step_y        = SPACING_RST;
			step_z        = SPACING_RST;
			seeds_held    = 0;
			words_out     = 0;
			errors        = 0;
			verdicts_due.delete();
			outstanding   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_VALUE_MIN: lim_lo        = cfg_data[VALUE_W-1:0];
					CFG_VALUE_MAX: lim_hi        = cfg_data[VALUE_W-1:0];
					CFG_OVERWRITE: may_overwrite = cfg_data[0];
					CFG_RADIUS_ON: radius_on     = cfg_data[0];
					CFG_RADIUS_SQ: rad_sq        = cfg_data[RADIUS_W-1:0];
					CFG_SPACING_X: step_x        = cfg_data[SPACING_W-1:0];
					CFG_SPACING_Y: step_y        = cfg_data[SPACING_W-1:0];
					CFG_SPACING_Z: step_z        = cfg_data[SPACING_W-1:0];
					default: ;
				endcase
			end
			// result side first, so a word taken at this edge cannot match it
			if (result_valid && result_ready) begin
				if (verdicts_due.size() == 0)
					report_mismatch("result with no word outstanding");
				else begin
					want = verdicts_due.pop_front();
					if (result.accept !== want.accept)
						report_mismatch($sformatf("accept is %0b, expected %0b",
							result.accept, want.accept));
					if (result.reason !== want.reason)
						report_mismatch($sformatf("reason is %0d, expected %0d",
							result.reason, want.reason));
					if (result.seed_total !== want.seed_total)
						report_mismatch($sformatf("seed_total is %0d, expected %0d",
							result.seed_total, want.seed_total));
				end
				words_out++;
			end
			if (item_valid && item_ready)
				verdicts_due = {verdicts_due, judge_word(item)};
			outstanding = verdicts_due.size();
		end
	end

endmodule

// ----- sim/region_grow_voxel_criterion_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_grow_voxel_criterion_test: stimulus and verdict for the voxel criterion
// directed seed and evaluate words, then random phases with changing registers
// and idle patterns; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module region_grow_voxel_criterion_test;
	import rgvc_pkg::*;

	// func code 3 has no meaning in the block and must be ignored
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam int RESET_CYCLES  = 7;
	// longest evaluate is one with a full table
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 113;
	// limit on the length of the whole run
	localparam int CYCLE_LIMIT   = 500000;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 item_word;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result_word;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int checker_errors;
	int words_due;
	int cycles = 0;

	// idle rates in percent, changed per phase
	int idle_pct;
	int stall_pct;

	// what the stimulus knows of the current settings
	int             val_lo;
	int             val_hi;
	logic [COORD_W-1:0] cx, cy, cz;

	region_grow_voxel_criterion dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rgvc_verdict_checker verdicts (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (checker_errors),
		.outstanding  (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: ready is redrawn every falling edge
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// all drive tasks are entered and left at a falling edge

	task automatic send_word(input item_t w);
		// sender gaps, drawn anew at each falling edge
		while ($urandom_range(99) < idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_word  = w;
		item_valid = 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// block goes idle once every word has its result back
	task automatic drain_block();
		item_valid = 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	function automatic item_t make_word(input logic [1:0] f, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
			input logic signed [VALUE_W-1:0] v, input logic roi);
		item_t w;
		w.func        = f;
		w.pos_x       = x;
		w.pos_y       = y;
		w.pos_z       = z;
		w.voxel_value = v;
		w.roi_ok      = roi;
		return w;
	endfunction

	// mostly near the phase's cluster center so the radius check bites
	function automatic logic [COORD_W-1:0] coord_near(input logic [COORD_W-1:0] c);
		int o;
		if ($urandom_range(99) < 20)
			return COORD_W'($urandom_range(0, 1023));
		o = int'(c);
		o = o + int'($urandom_range(0, 48)) - 24;
		return o[COORD_W-1:0];
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int k;
		int v;
		k = $urandom_range(9);
		if (k < 3)
			v = 0;
		else if (k < 7 && val_lo <= val_hi)
			v = val_lo + int'($urandom_range(0, val_hi - val_lo));
		else
			v = $urandom_range(0, 65535);
		return v[VALUE_W-1:0];
	endfunction

	function automatic item_t random_word();
		int         k;
		logic [1:0] f;
		k = $urandom_range(99);
		if (k < 62)
			f = FUNC_EVAL;
		else if (k < 94)
			f = FUNC_APPEND;
		else if (k < 98)
			f = FUNC_CLEAR;
		else
			f = FUNC_SPARE;
		return make_word(f, coord_near(cx), coord_near(cy), coord_near(cz),
			pick_value(), $urandom_range(99) < 85);
	endfunction

	function automatic logic [SPACING_W-1:0] pick_spacing();
		if ($urandom_range(9) == 0)
			return SPACING_W'($urandom_range(0, 65535));
		return SPACING_W'($urandom_range(128, 640));
	endfunction

	// phase 0 and 1 sit at the register extremes, phase 2 has an empty range
	task automatic pick_settings(input int phase);
		int                   lo, hi, swap, r;
		logic                 ow, ron;
		logic [RADIUS_W-1:0]  rsq;
		logic [SPACING_W-1:0] sx, sy, sz;
		case (phase)
			0: begin
				lo = -32768; hi = 32767; ow = 1'b1; ron = 1'b1;
				rsq = '1; sx = '1; sy = '1; sz = '1;
			end
			1: begin
				// zero spacing puts every voxel on its seed, so any seed is near
				lo = 0; hi = 0; ow = 1'b0; ron = 1'b1;
				rsq = 56'd1; sx = '0; sy = '0; sz = '0;
			end
			2: begin
				lo = 100; hi = -100; ow = 1'b1; ron = 1'b0;
				rsq = '0; sx = pick_spacing(); sy = pick_spacing(); sz = pick_spacing();
			end
			default: begin
				lo = -int'($urandom_range(0, 3000));
				hi = $urandom_range(0, 3000);
				if ($urandom_range(9) == 0) begin
					swap = lo; lo = hi; hi = swap;
				end
				ow  = 1'($urandom_range(1));
				ron = ($urandom_range(99) < 75);
				if ($urandom_range(9) == 0)
					rsq = RADIUS_W'({$urandom, $urandom});
				else begin
					r   = $urandom_range(1, 40);
					rsq = (RADIUS_W'(r * r) << 16) | RADIUS_W'($urandom_range(0, 65535));
				end
				sx = pick_spacing(); sy = pick_spacing(); sz = pick_spacing();
			end
		endcase
		val_lo = lo;
		val_hi = hi;
		write_reg(CFG_VALUE_MIN, CFG_DATA_W'(lo));
		write_reg(CFG_VALUE_MAX, CFG_DATA_W'(hi));
		write_reg(CFG_OVERWRITE, CFG_DATA_W'(ow));
		write_reg(CFG_RADIUS_ON, CFG_DATA_W'(ron));
		write_reg(CFG_RADIUS_SQ, rsq);
		write_reg(CFG_SPACING_X, CFG_DATA_W'(sx));
		write_reg(CFG_SPACING_Y, CFG_DATA_W'(sy));
		write_reg(CFG_SPACING_Z, CFG_DATA_W'(sz));
		cx = COORD_W'($urandom_range(0, 1023));
		cy = COORD_W'($urandom_range(0, 1023));
		cz = COORD_W'($urandom_range(0, 1023));
	endtask

	initial begin
		item_valid = 1'b0;
		item_word  = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_VALUE_MIN;
		cfg_data   = '0;
		idle_pct   = 0;
		stall_pct  = 0;
		val_lo     = -32768;
		val_hi     = 32767;
		cx = '0; cy = '0; cz = '0;
		arst_n     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed words on the reset settings: full range, no overwrite,
		// radius check off
		send_word(make_word(FUNC_EVAL, 10'd0, 10'd0, 10'd0, 16'sd0, 1'b1));
		send_word(make_word(FUNC_EVAL, 10'd1023, 10'd1023, 10'd1023, -16'sd32768, 1'b1));
		send_word(make_word(FUNC_EVAL, 10'd512, 10'd5, 10'd1000, 16'sd32767, 1'b0));
		// zero voxel outside the roi
		send_word(make_word(FUNC_EVAL, 10'd3, 10'd700, 10'd9, 16'sd0, 1'b0));
		// unused func code leaves the table alone
		send_word(make_word(FUNC_SPARE, 10'd1023, 10'd0, 10'd1023, -16'sd1, 1'b1));
		send_word(make_word(FUNC_APPEND, 10'd1023, 10'd0, 10'd1023, 16'sd0, 1'b0));
		send_word(make_word(FUNC_CLEAR, 10'd0, 10'd1023, 10'd0, 16'sd0, 1'b1));
		drain_block();

		// narrow range, overwrite on, radius of three voxels, uneven spacing
		val_lo = -5;
		val_hi = 5;
		write_reg(CFG_VALUE_MIN, CFG_DATA_W'(-5));
		write_reg(CFG_VALUE_MAX, CFG_DATA_W'(5));
		write_reg(CFG_OVERWRITE, CFG_DATA_W'(1));
		write_reg(CFG_RADIUS_ON, CFG_DATA_W'(1));
		write_reg(CFG_RADIUS_SQ, 56'd589824);
		write_reg(CFG_SPACING_X, 56'd256);
		write_reg(CFG_SPACING_Y, 56'd512);
		write_reg(CFG_SPACING_Z, 56'd128);
		// radius check against an empty table finds no seed
		send_word(make_word(FUNC_EVAL, 10'd100, 10'd100, 10'd100, 16'sd1, 1'b1));
		// fill the table, then one append too many
		for (int i = 0; i < 16; i++)
			send_word(make_word(FUNC_APPEND, COORD_W'(i * 68), COORD_W'(1023 - i * 68),
				COORD_W'(i * 60 + 123), 16'sd0, 1'b1));
		send_word(make_word(FUNC_APPEND, 10'd1, 10'd2, 10'd3, 16'sd0, 1'b1));
		// two voxels off seed 5 along x, inside the radius
		send_word(make_word(FUNC_EVAL, 10'd342, 10'd683, 10'd423, 16'sd5, 1'b1));
		send_word(make_word(FUNC_EVAL, 10'd340, 10'd683, 10'd423, 16'sd6, 1'b1));
		drain_block();

		// empty value range: every voxel is out of range
		val_lo = 10;
		val_hi = -10;
		write_reg(CFG_VALUE_MIN, CFG_DATA_W'(10));
		write_reg(CFG_VALUE_MAX, CFG_DATA_W'(-10));
		send_word(make_word(FUNC_EVAL, 10'd0, 10'd0, 10'd0, 16'sd0, 1'b1));

		// --- random phases, each with its own settings and idle pattern
		for (int p = 0; p < PHASES; p++) begin
			drain_block();
			pick_settings(p);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 46; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 46; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// hold the sender off midway until every result is back
				if (n == PHASE_WORDS / 2)
					drain_block();
				send_word(random_word());
			end
		end

		drain_block();
		if (checker_errors == 0 && words_due == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
